FILE: rtl/core/command_frame_checker_core_defines.svh
// assertion macros for the command frame checker
// each macro needs clk and rst_n in scope at the point of use
`ifndef COMMAND_FRAME_CHECKER_CORE_DEFINES_SVH
`define COMMAND_FRAME_CHECKER_CORE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define CFC_ASSERT_NOW(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error(msg);

// next-cycle implication
`define CFC_ASSERT_NEXT(lbl, ant, con, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error(msg);

`else

`define CFC_ASSERT_NOW(lbl, ant, con, msg)
`define CFC_ASSERT_NEXT(lbl, ant, con, msg)

`endif

`endif

FILE: rtl/core/cfc_pkg.sv
`timescale 1ns / 1ps

package cfc_pkg;

    // command code after reset
    localparam logic [7:0] CMD_RESET_VALUE = 8'hCD;
    // sequence xor its complement must give this
    localparam logic [7:0] SEQ_CHECK = 8'hFF;

    // frame byte positions
    localparam logic [3:0] POS_CMD     = 4'd0;
    localparam logic [3:0] POS_SEQ     = 4'd1;
    localparam logic [3:0] POS_SEQ_INV = 4'd2;
    localparam logic [3:0] POS_ADDR0   = 4'd3;
    localparam logic [3:0] POS_ADDR1   = 4'd4;
    localparam logic [3:0] POS_ADDR2   = 4'd5;
    localparam logic [3:0] POS_ADDR3   = 4'd6;
    localparam logic [3:0] POS_CRC_HI  = 4'd7;
    localparam logic [3:0] POS_CRC_LO  = 4'd8;

    // crc-16, polynomial 0x1021, one entry per nibble
    localparam logic [15:0] NIB_TABLE [16] = '{
        16'h0000, 16'h1021, 16'h2042, 16'h3063,
        16'h4084, 16'h50A5, 16'h60C6, 16'h70E7,
        16'h8108, 16'h9129, 16'hA14A, 16'hB16B,
        16'hC18C, 16'hD1AD, 16'hE1CE, 16'hF1EF
    };

    // control from the frame tracker to the crc unit
    typedef struct packed {
        logic restart;
        logic finish;
    } crc_ctl_t;

    function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
        logic [3:0] idx;
        idx = crc[15:12] ^ nib;
        return {crc[11:0], 4'h0} ^ NIB_TABLE[idx];
    endfunction

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] mid;
        mid = crc_nibble(crc, b[7:4]);
        return crc_nibble(mid, b[3:0]);
    endfunction

endpackage

FILE: rtl/core/cfc_if.sv
`timescale 1ns / 1ps

// received byte channel
interface cfc_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink (input valid, input rx_byte, input frame_start, output ready);
endinterface

// frame result channel
interface cfc_result_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [7:0]  sequence_number;
    logic [31:0] address;

    modport source (output valid, output frame_ok, output sequence_number,
                    output address, input ready);
    modport sink (input valid, input frame_ok, input sequence_number,
                  input address, output ready);
endinterface

// command code write channel
interface cfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/cfc_crc_unit.sv
`timescale 1ns / 1ps

module cfc_crc_unit
    import cfc_pkg::*;
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    input  crc_ctl_t    ctl,
    output logic [15:0] crc_out
);

    logic [15:0] seed;
    logic [15:0] after_data;
    logic [15:0] after_pad;

    // fresh frame starts from zero
    assign seed = ctl.restart ? 16'h0000 : crc_in;

    // data byte, high nibble first
    assign after_data = crc_byte(seed, data);

    // two zero bytes close the checksum
    assign after_pad = crc_byte(crc_byte(after_data, 8'h00), 8'h00);

    assign crc_out = ctl.finish ? after_pad : after_data;

endmodule

FILE: rtl/core/command_frame_checker_core.sv
`timescale 1ns / 1ps
`include "command_frame_checker_core_defines.svh"

// command frame checker
// rx carries one frame byte per beat; frame_start forces the byte to be
// frame byte zero and drops any partial frame without a result.
// a frame is nine bytes: command, sequence, complement, four address
// bytes (little-endian) and a big-endian crc-16 over the first seven.
// result carries one beat per frame, taken at the ninth byte: frame_ok,
// the sequence number and the address, reported even for a bad frame.
// cfg writes the command code, always ready; the user must write it only while idle (unenforced).
// throughput: one byte per cycle, set by the single crc and compare stage
// between the frame state and the result register.
// latency: the result is valid the cycle after the ninth byte is accepted.
// when the receiver stalls the result register holds; while a result waits
// untaken, rx is held off until the receiver takes it.
// reset: frame position zero, checksum and holds cleared, command code 0xCD,
// no result pending.
module command_frame_checker_core
    import cfc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    cfc_rx_if.sink        rx,
    cfc_result_if.source  result,
    cfc_cfg_if.sink       cfg
);

    logic [7:0]  cmd_code_reg;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next, crc_calc;
    logic [7:0]  seq_reg, seq_next;
    logic [31:0] addr_reg, addr_next;
    logic        hdr_err_reg, hdr_err_next;
    logic [7:0]  crc_hi_reg, crc_hi_next;

    logic        out_valid_reg;
    logic        ok_reg;
    logic [7:0]  seq_out_reg;
    logic [31:0] addr_out_reg;

    logic        rx_acc;
    logic        res_take;
    logic        emit;
    logic        frame_good;
    logic [3:0]  pos_eff;
    crc_ctl_t    crc_ctl;

    // handshakes
    assign cfg.ready = 1'b1;
    assign res_take  = out_valid_reg && result.ready;
    assign rx.ready  = !out_valid_reg || result.ready;
    assign rx_acc    = rx.valid && rx.ready;

    // effective position of this byte
    assign pos_eff = (rx.frame_start || pos_reg > POS_CRC_LO) ? POS_CMD : pos_reg;

    // checksum update
    assign crc_ctl.restart = (pos_eff == POS_CMD);
    assign crc_ctl.finish  = (pos_eff == POS_ADDR3);

    cfc_crc_unit u_crc (
        .crc_in  (crc_reg),
        .data    (rx.rx_byte),
        .ctl     (crc_ctl),
        .crc_out (crc_calc)
    );

    assign frame_good = !hdr_err_reg && ({crc_hi_reg, rx.rx_byte} == crc_reg);

    // frame tracking
    always_comb
    begin
        pos_next     = pos_eff + 4'd1;
        crc_next     = crc_reg;
        seq_next     = seq_reg;
        addr_next    = addr_reg;
        hdr_err_next = hdr_err_reg;
        crc_hi_next  = crc_hi_reg;
        emit         = 1'b0;
        unique case (pos_eff)
            POS_CMD:
            begin
                hdr_err_next = (rx.rx_byte != cmd_code_reg);
                crc_next     = crc_calc;
                addr_next    = '0;
                seq_next     = '0;
            end
            POS_SEQ:
            begin
                seq_next = rx.rx_byte;
                crc_next = crc_calc;
            end
            POS_SEQ_INV:
            begin
                if ((seq_reg ^ rx.rx_byte) != SEQ_CHECK)
                begin
                    hdr_err_next = 1'b1;
                end
                crc_next = crc_calc;
            end
            POS_ADDR0:
            begin
                addr_next[7:0] = rx.rx_byte;
                crc_next       = crc_calc;
            end
            POS_ADDR1:
            begin
                addr_next[15:8] = rx.rx_byte;
                crc_next        = crc_calc;
            end
            POS_ADDR2:
            begin
                addr_next[23:16] = rx.rx_byte;
                crc_next         = crc_calc;
            end
            POS_ADDR3:
            begin
                addr_next[31:24] = rx.rx_byte;
                crc_next         = crc_calc;
            end
            POS_CRC_HI:
            begin
                crc_hi_next = rx.rx_byte;
            end
            POS_CRC_LO:
            begin
                emit     = 1'b1;
                pos_next = POS_CMD;
            end
            default:
            begin
                pos_next = POS_CMD;
            end
        endcase
    end

    // frame state and command code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_code_reg <= CMD_RESET_VALUE;
            pos_reg      <= POS_CMD;
            crc_reg      <= '0;
            seq_reg      <= '0;
            addr_reg     <= '0;
            hdr_err_reg  <= 1'b0;
            crc_hi_reg   <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                cmd_code_reg <= cfg.data;
            end
            if (rx_acc)
            begin
                pos_reg     <= pos_next;
                crc_reg     <= crc_next;
                seq_reg     <= seq_next;
                addr_reg    <= addr_next;
                hdr_err_reg <= hdr_err_next;
                crc_hi_reg  <= crc_hi_next;
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rx_acc && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (rx_acc && emit)
        begin
            ok_reg       <= frame_good;
            seq_out_reg  <= seq_reg;
            addr_out_reg <= addr_reg;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.frame_ok        = ok_reg;
    assign result.sequence_number = seq_out_reg;
    assign result.address         = addr_out_reg;

    // checks
    `CFC_ASSERT_NEXT(a_last_byte_gives_result, rx_acc && emit, out_valid_reg,
        "ninth byte did not raise a result")
    `CFC_ASSERT_NEXT(a_no_spurious_result,
        rx_acc && !emit && (!out_valid_reg || result.ready), !out_valid_reg,
        "result raised without a ninth byte")
    `CFC_ASSERT_NEXT(a_wrap_after_last, rx_acc && pos_eff == POS_CRC_LO,
        pos_reg == POS_CMD, "frame position did not wrap after the ninth byte")

endmodule
